[rtl/md5_message_digest_defines.svh]
// Assertion macros shared by the MD5 digest design.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define MD5_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define MD5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

[rtl/md5_pkg.sv]
// Package with MD5 constants, tables, types and round functions.
package md5_pkg;
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [31:0] PAD_BYTE = 32'h00000080;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FILL, ST_COMP, ST_FIN, ST_OUT
	} md5_state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} md5_ctl_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] S_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] r;
		logic [3:0] lo;
		lo = i[3:0];
		case (i[5:4])
			2'd0: r = lo;
			2'd1: r = 4'((lo << 2) + lo + 4'd1);
			2'd2: r = 4'((lo << 1) + lo + 4'd5);
			default: r = 4'((lo << 3) - lo);
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] ph,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] r;
		case (ph)
			2'd0: r = (b & c) | (~b & d);
			2'd1: r = (b & d) | (c & ~d);
			2'd2: r = b ^ c ^ d;
			default: r = c ^ (b | ~d);
		endcase
		return r;
	endfunction
endpackage

[rtl/md5_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
module md5_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/md5_round.sv]
// Shared MD5 round unit stepping through 64 rounds of one block.
`include "md5_message_digest_defines.svh"
module md5_round (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       msg_word,
	output logic [3:0]        msg_addr,
	output md5_pkg::md5_ctl_t ctl,
	output logic [31:0]       ch_a,
	output logic [31:0]       ch_b,
	output logic [31:0]       ch_c,
	output logic [31:0]       ch_d,
	input  logic              reinit
);
	import md5_pkg::*;

	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] ca_q, cb_q, cc_q, cd_q;
	logic [6:0]  rnd_q;
	logic        busy_q, done_q;
	logic [5:0]  ri;
	logic [31:0] t_sum, t_rot, t_new;
	logic [4:0]  sh;

	assign ri = rnd_q[5:0];
	assign msg_addr = busy_q ? msg_index(6'(ri + 6'd1)) : msg_index(6'd0);
	assign sh = S_TAB[{ri[5:4], ri[1:0]}];
	assign t_sum = a_q + round_f(ri[5:4], b_q, c_q, d_q) + msg_word + K_TAB[ri];
	assign t_rot = (t_sum << sh) | (t_sum >> (6'd32 - {1'b0, sh}));
	assign t_new = t_rot + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
			ca_q <= IV_A;
			cb_q <= IV_B;
			cc_q <= IV_C;
			cd_q <= IV_D;
		end else begin
			done_q <= 1'b0;
			if (reinit) begin
				ca_q <= IV_A;
				cb_q <= IV_B;
				cc_q <= IV_C;
				cd_q <= IV_D;
			end else if (start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				if (rnd_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ca_q <= ca_q + d_q;
					cb_q <= cb_q + t_new;
					cc_q <= cc_q + b_q;
					cd_q <= cd_q + c_q;
				end
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= ca_q;
			b_q <= cb_q;
			c_q <= cc_q;
			d_q <= cd_q;
		end else if (busy_q) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= t_new;
		end
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
	assign ch_a = ca_q;
	assign ch_b = cb_q;
	assign ch_c = cc_q;
	assign ch_d = cd_q;

	`MD5_ASSERT_NEXT(a_done_end, clk, arst_n, busy_q && rnd_q == 7'd63, done_q && !busy_q,
		"round unit did not finish after round 63")
	`MD5_ASSERT_IMPL(a_rnd_range, clk, arst_n, busy_q, rnd_q < 7'd64, "round count overrun")
	`MD5_ASSERT_IMPL(a_no_restart, clk, arst_n, start, !busy_q, "block started while busy")
endmodule

[rtl/md5_message_digest.sv]
// Top level of the MD5 digest: word buffer, padding sequencer and round unit.
// A full word is written to the buffer when taken; the sixteenth word of a block
// starts the 64 rounds of the shared round unit and then the chaining update.
// A last word adds padding words and one or two blocks, then the digest
// is held until taken. No word is taken while a block is in the rounds.
// Reset is asynchronous, active low, and restores the initial chaining words.
`include "md5_message_digest_defines.svh"
module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_a,
	output logic [31:0] digest_b,
	output logic [31:0] digest_c,
	output logic [31:0] digest_d
);
	import md5_pkg::*;

	md5_state_t  state_q, state_d;
	logic [3:0]  pos_q;
	logic [63:0] bits_q;
	logic        lenhi_q;
	logic        we;
	logic [3:0]  waddr;
	logic [31:0] wdata;
	logic [3:0]  raddr;
	logic [31:0] rdata;
	logic        start, reinit, take;
	md5_ctl_t    ctl;
	logic [31:0] ch_a, ch_b, ch_c, ch_d;
	logic [2:0]  nb;
	logic [31:0] lastw, mask;
	logic [63:0] bits_next;
	logic        fin_after;
	logic        fin_after_q;
	logic        fill_after;
	logic        fill_after_q;
	logic [31:0] dg_a_q, dg_b_q, dg_c_q, dg_d_q;

	md5_ram #(.Width(32), .Depth(16)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	md5_round u_round (
		.clk(clk), .arst_n(arst_n), .start(start), .msg_word(rdata), .msg_addr(raddr),
		.ctl(ctl), .ch_a(ch_a), .ch_b(ch_b), .ch_c(ch_c), .ch_d(ch_d), .reinit(reinit)
	);

	assign take = in_valid && !in_stall;
	assign nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
	assign mask = (nb == 3'd4) ? 32'hffffffff : ((32'd1 << {nb, 3'b000}) - 32'd1);
	assign lastw = (nb == 3'd4) ? data_word : ((data_word & mask) | (PAD_BYTE << {nb, 3'b000}));
	assign bits_next = bits_q + (last_word ? 64'({nb, 3'b000}) : 64'd32);

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = pos_q;
		wdata = '0;
		start = 1'b0;
		reinit = 1'b0;
		fin_after = 1'b0;
		fill_after = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (take) begin
					we = 1'b1;
					wdata = last_word ? lastw : data_word;
					if (last_word) begin
						state_d = (nb == 3'd4) ? ST_FILL : ST_FIN;
						if (pos_q == 4'd15) begin
							state_d = ST_COMP;
							start = 1'b1;
							fill_after = (nb == 3'd4);
							fin_after = (nb != 3'd4);
						end
					end
					if (!last_word && pos_q == 4'd15) begin
						start = 1'b1;
						state_d = ST_COMP;
					end
				end
			end
			ST_FILL: begin
				we = 1'b1;
				wdata = PAD_BYTE;
				if (pos_q == 4'd15) begin
					start = 1'b1;
					state_d = ST_COMP;
					fin_after = 1'b1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				we = 1'b1;
				if (pos_q == 4'd14) begin
					wdata = bits_q[31:0];
				end else if (pos_q == 4'd15 && lenhi_q) begin
					wdata = bits_q[63:32];
					start = 1'b1;
					state_d = ST_COMP;
				end else if (pos_q == 4'd15) begin
					start = 1'b1;
					state_d = ST_COMP;
					fin_after = 1'b1;
				end
			end
			ST_COMP: begin
				if (ctl.done) begin
					state_d = lenhi_q ? ST_OUT :
						(fill_after_q ? ST_FILL : (fin_after_q ? ST_FIN : ST_IDLE));
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
					reinit = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			bits_q <= '0;
			lenhi_q <= 1'b0;
			fin_after_q <= 1'b0;
			fill_after_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				fin_after_q <= fin_after;
				fill_after_q <= fill_after;
			end
			if (we) begin
				pos_q <= pos_q + 4'd1;
			end
			if (state_q == ST_IDLE && take) begin
				bits_q <= bits_next;
			end
			if (state_q == ST_FIN && pos_q == 4'd14) begin
				lenhi_q <= 1'b1;
			end
			if (reinit) begin
				pos_q <= '0;
				bits_q <= '0;
				lenhi_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COMP && ctl.done && lenhi_q) begin
			dg_a_q <= ch_a;
			dg_b_q <= ch_b;
			dg_c_q <= ch_c;
			dg_d_q <= ch_d;
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign digest_a = dg_a_q;
	assign digest_b = dg_b_q;
	assign digest_c = dg_c_q;
	assign digest_d = dg_d_q;

	`MD5_ASSERT_IMPL(a_stall_busy, clk, arst_n, ctl.busy, in_stall, "word taken during rounds")
	`MD5_ASSERT_IMPL(a_out_state, clk, arst_n, out_valid, !ctl.busy, "digest shown mid-block")
	`MD5_ASSERT_NEXT(a_reinit, clk, arst_n, out_valid && !out_stall,
		pos_q == 4'd0 && bits_q == 64'd0, "state not cleared after digest")
endmodule

[bench/testbench.sv]
// Self-checking testbench for the MD5 message digest block with a scoreboard class.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import md5_pkg::*;

	typedef struct {
		logic [31:0] a, b, c, d;
	} digest_t;

	class digest_scoreboard;
		logic [31:0] chain[4];
		logic [31:0] blk[16];
		int unsigned wpos;
		logic [63:0] nbits;
		digest_t pending[$];
		int errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			chain[0] = IV_A;
			chain[1] = IV_B;
			chain[2] = IV_C;
			chain[3] = IV_D;
			wpos = 0;
			nbits = '0;
		endfunction

		function void compress();
			logic [31:0] a, b, c, d, f, t, m;
			int unsigned g, ph, s;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (int i = 0; i < 64; i++) begin
				ph = i / 16;
				case (ph)
					0: begin
						f = (b & c) | (~b & d);
						g = i;
					end
					1: begin
						f = (b & d) | (c & ~d);
						g = (5 * i + 1) % 16;
					end
					2: begin
						f = b ^ c ^ d;
						g = (3 * i + 5) % 16;
					end
					default: begin
						f = c ^ (b | ~d);
						g = (7 * i) % 16;
					end
				endcase
				t = a + f + blk[g] + K_TAB[i];
				s = S_TAB[ph * 4 + i % 4];
				m = (t << s) | (t >> (32 - s));
				a = d;
				d = c;
				c = b;
				b = m + b;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
		endfunction

		function void add_word(logic [31:0] w);
			blk[wpos] = w;
			wpos = (wpos + 1) % 16;
			if (wpos == 0)
				compress();
		endfunction

		function void note_word(logic [31:0] data, logic [2:0] nb, logic last);
			int unsigned n;
			logic [31:0] w;
			digest_t dg;
			if (!last) begin
				nbits += 64'd32;
				add_word(data);
				return;
			end
			n = (nb > 4) ? 4 : nb;
			nbits += 64'(8 * n);
			if (n == 4) begin
				add_word(data);
				add_word(PAD_BYTE);
			end else begin
				w = data & ((32'h1 << (8 * n)) - 1);
				w |= PAD_BYTE << (8 * n);
				add_word(w);
			end
			while (wpos != 14)
				add_word('0);
			add_word(nbits[31:0]);
			add_word(nbits[63:32]);
			dg.a = chain[0];
			dg.b = chain[1];
			dg.c = chain[2];
			dg.d = chain[3];
			pending.push_back(dg);
			clear();
		endfunction

		function void check_digest(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d);
			digest_t e;
			if (pending.size() == 0) begin
				$display("%0t: digest with none expected: %h %h %h %h", $time, a, b, c, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a !== e.a) begin
				$display("%0t: digest_a expected %h actual %h", $time, e.a, a);
				errors++;
			end
			if (b !== e.b) begin
				$display("%0t: digest_b expected %h actual %h", $time, e.b, b);
				errors++;
			end
			if (c !== e.c) begin
				$display("%0t: digest_c expected %h actual %h", $time, e.c, c);
				errors++;
			end
			if (d !== e.d) begin
				$display("%0t: digest_d expected %h actual %h", $time, e.d, d);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] data_word = '0;
	logic [2:0] valid_bytes = '0;
	logic last_word = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [31:0] digest_a, digest_b, digest_c, digest_d;
	bit calm = 0;
	digest_scoreboard sb = new();

	md5_message_digest i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_word(data_word), .valid_bytes(valid_bytes), .last_word(last_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_a(digest_a), .digest_b(digest_b),
		.digest_c(digest_c), .digest_d(digest_d)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_digest(digest_a, digest_b, digest_c, digest_d);
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 19);
		end
	end

	task automatic send_word(logic [31:0] data, logic [2:0] nb, logic last);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		data_word <= data;
		valid_bytes <= nb;
		last_word <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(data, nb, last);
	endtask

	task automatic send_message(int unsigned nfull, logic [31:0] tail, logic [2:0] nb);
		for (int unsigned i = 0; i < nfull; i++)
			send_word($urandom, 3'($urandom_range(7)), 1'b0);
		send_word(tail, nb, 1'b1);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned n;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: empty messages, every tail length, block boundaries.
		send_word('0, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd7, 1'b1);
		for (int nb = 0; nb < 8; nb++)
			send_message(0, 32'hffffffff, 3'(nb));
		send_message(13, 32'h00000000, 3'd4);
		send_message(14, 32'hffffffff, 3'd1);
		send_message(15, 32'hffffffff, 3'd0);
		send_message(15, 32'h12345678, 3'd4);
		send_message(16, 32'h5a5aa5a5, 3'd3);
		drain();
		sent = 0;
		while (sent < 1700) begin
			calm = (sent >= 600 && sent < 900);
			if ($urandom_range(9) == 0)
				n = $urandom_range(40);
			else
				n = $urandom_range(18);
			send_message(n, $urandom, 3'($urandom_range(7)));
			sent += n + 1;
			if (sent > 1200 && sent < 1240)
				drain();
		end
		calm = 0;
		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#10000000;
		$display("tb: failure");
		$finish;
	end
endmodule
